@@ src/fragment_clip_alpha_test_blend_macros.svh @@
// Assertion macros for the fragment back end checker.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef FRAGMENT_CLIP_ALPHA_TEST_BLEND_MACROS_SVH
`define FRAGMENT_CLIP_ALPHA_TEST_BLEND_MACROS_SVH

// same-cycle implication
`define FCATB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FCATB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/fcatb_pkg.sv @@
// Shared types and constants of the fragment clip / alpha test / blend block.
// No dependencies; used by fcatb_if, fcatb_chan and the top level.
package fcatb_pkg;

    localparam int COORD_W        = 13;
    localparam int COLOR_W        = 32;
    localparam int CFG_ADDR_W     = 4;
    localparam int CFG_DATA_W     = 52;
    localparam int MAX_RECTS      = 4;
    localparam int COORD_BIAS_DEF = 1440;
    localparam int CLIP_RECTS_DEF = 4;

    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

    localparam cfg_addr_t REG_BLEND   = 4'd0;
    localparam cfg_addr_t REG_ALPHA   = 4'd1;
    localparam cfg_addr_t REG_CLIP    = 4'd2;
    localparam cfg_addr_t REG_RECT0   = 4'd3;
    localparam cfg_addr_t REG_TEXTURE = 4'd7;

    localparam logic [15:0] CLIP_ALL = 16'hffff;

    localparam logic [2:0] SWZ_ZERO = 3'd4;
    localparam logic [2:0] SWZ_ONE  = 3'd5;

    typedef enum logic [2:0] {
        AF_NEVER,
        AF_LESS,
        AF_EQUAL,
        AF_LEQUAL,
        AF_GTHAN,
        AF_NOTEQUAL,
        AF_GEQUAL,
        AF_ALWAYS
    } alpha_func_t;

    typedef struct packed {
        logic       enable;
        logic [5:0] src_code;
        logic [5:0] dst_code;
    } blend_ctl_t;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } stage_en_t;

endpackage

@@ src/fcatb_if.sv @@
// Valid/ready channel interfaces: fragment in, result out, register writes.
// Depends on fcatb_pkg for field widths.
interface fcatb_frag_if;
    logic                              valid;
    logic                              ready;
    logic [fcatb_pkg::COORD_W-1:0]     pixel_x;
    logic [fcatb_pkg::COORD_W-1:0]     pixel_y;
    logic [fcatb_pkg::COLOR_W-1:0]     source_color;
    logic [fcatb_pkg::COLOR_W-1:0]     texel_color;
    logic [fcatb_pkg::COLOR_W-1:0]     dest_color;

    modport source (output valid, pixel_x, pixel_y, source_color, texel_color, dest_color,
                    input ready);
    modport sink   (input valid, pixel_x, pixel_y, source_color, texel_color, dest_color,
                    output ready);
endinterface

interface fcatb_result_if;
    logic                              valid;
    logic                              ready;
    logic                              write_enable;
    logic [fcatb_pkg::COLOR_W-1:0]     result_color;

    modport source (output valid, write_enable, result_color, input ready);
    modport sink   (input valid, write_enable, result_color, output ready);
endinterface

interface fcatb_cfg_if;
    logic                              valid;
    logic                              ready;
    fcatb_pkg::cfg_addr_t              addr;
    logic [fcatb_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

@@ src/fcatb_chan.sv @@
// One color channel of the blend pipeline: factor select, products, clamp, divide.
// Depends on fcatb_pkg; stages advance on the enables from the top level.
module fcatb_chan (
    input  logic                  clk,
    input  fcatb_pkg::stage_en_t  en,
    input  fcatb_pkg::blend_ctl_t ctl,
    input  logic [15:0]           sc,
    input  logic [15:0]           sa,
    input  logic [7:0]            d,
    input  logic [7:0]            da,
    output logic [7:0]            q
);

    localparam logic [15:0] UNIT_ONE  = 16'd65025;
    localparam logic [31:0] BLEND_LIM = 32'd4228250625;
    localparam logic [31:0] BLEND_DIV = 32'd16581375;
    localparam logic [8:0]  RECIP     = 9'd259;

    localparam logic [5:0] BF_ZERO       = 6'd1;
    localparam logic [5:0] BF_ONE        = 6'd2;
    localparam logic [5:0] BF_SRC        = 6'd3;
    localparam logic [5:0] BF_INV_SRC    = 6'd4;
    localparam logic [5:0] BF_SRC_A      = 6'd5;
    localparam logic [5:0] BF_INV_SRC_A  = 6'd6;
    localparam logic [5:0] BF_DST_A      = 6'd7;
    localparam logic [5:0] BF_INV_DST_A  = 6'd8;
    localparam logic [5:0] BF_DST        = 6'd9;
    localparam logic [5:0] BF_INV_DST    = 6'd10;
    localparam logic [5:0] BF_SAT        = 6'd11;
    localparam logic [5:0] BX_ZERO       = 6'd32;
    localparam logic [5:0] BX_ONE        = 6'd33;
    localparam logic [5:0] BX_SRC        = 6'd34;
    localparam logic [5:0] BX_INV_SRC    = 6'd35;
    localparam logic [5:0] BX_DST        = 6'd36;
    localparam logic [5:0] BX_INV_DST    = 6'd37;
    localparam logic [5:0] BX_SRC_A      = 6'd38;
    localparam logic [5:0] BX_INV_SRC_A  = 6'd39;
    localparam logic [5:0] BX_DST_A      = 6'd40;
    localparam logic [5:0] BX_INV_DST_A  = 6'd41;
    localparam logic [5:0] BX_SAT        = 6'd42;

    function automatic logic [15:0] factor(
        input logic [5:0]  code,
        input logic [15:0] fc,
        input logic [15:0] fa,
        input logic [15:0] fdc,
        input logic [15:0] fda
    );
        logic [15:0] inv_da;
        logic [15:0] f;
        inv_da = UNIT_ONE - fda;
        case (code)
            BF_ZERO, BX_ZERO:           f = '0;
            BF_ONE, BX_ONE:             f = UNIT_ONE;
            BF_SRC, BX_SRC:             f = fc;
            BF_INV_SRC, BX_INV_SRC:     f = UNIT_ONE - fc;
            BF_DST, BX_DST:             f = fdc;
            BF_INV_DST, BX_INV_DST:     f = UNIT_ONE - fdc;
            BF_SRC_A, BX_SRC_A:         f = fa;
            BF_INV_SRC_A, BX_INV_SRC_A: f = UNIT_ONE - fa;
            BF_DST_A, BX_DST_A:         f = fda;
            BF_INV_DST_A, BX_INV_DST_A: f = inv_da;
            BF_SAT, BX_SAT:             f = (fa < inv_da) ? fa : inv_da;
            default:                    f = UNIT_ONE;
        endcase
        return f;
    endfunction

    logic [15:0] dc;
    logic [15:0] da255;
    logic [15:0] fs_next;
    logic [15:0] fd_next;
    logic [32:0] sum;
    logic [31:0] sum_next;
    logic [40:0] est;
    logic [31:0] rem;
    logic [7:0]  q_next;

    logic [15:0] sc_a_reg;
    logic [15:0] dc_a_reg;
    logic [15:0] fs_a_reg;
    logic [15:0] fd_a_reg;
    logic [31:0] ps_b_reg;
    logic [31:0] pd_b_reg;
    logic [31:0] sum_c_reg;
    logic [31:0] sum_d_reg;
    logic [7:0]  qe_d_reg;
    logic [7:0]  q_reg;

    // factor select; blending off reduces to sc * one / 255^3 = sc / 255
    always_comb
    begin
        dc      = {d, 8'h00} - {8'h00, d};
        da255   = {da, 8'h00} - {8'h00, da};
        fs_next = ctl.enable ? factor(ctl.src_code, sc, sa, dc, da255) : UNIT_ONE;
        fd_next = ctl.enable ? factor(ctl.dst_code, sc, sa, dc, da255) : 16'd0;
    end

    always_comb
    begin
        sum      = {1'b0, ps_b_reg} + {1'b0, pd_b_reg};
        sum_next = (sum > {1'b0, BLEND_LIM}) ? BLEND_LIM : sum[31:0];
        est      = 41'(sum_c_reg) * 41'(RECIP);
        // estimate is low by at most one
        rem      = sum_d_reg - (32'(qe_d_reg) * BLEND_DIV);
        q_next   = qe_d_reg + 8'(rem >= BLEND_DIV);
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            sc_a_reg <= sc;
            dc_a_reg <= dc;
            fs_a_reg <= fs_next;
            fd_a_reg <= fd_next;
        end
        if (en.s3)
        begin
            ps_b_reg <= 32'(sc_a_reg) * 32'(fs_a_reg);
            pd_b_reg <= 32'(dc_a_reg) * 32'(fd_a_reg);
        end
        if (en.s4)
        begin
            sum_c_reg <= sum_next;
        end
        if (en.s5)
        begin
            sum_d_reg <= sum_c_reg;
            qe_d_reg  <= est[39:32];
        end
        if (en.s6)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

@@ src/fragment_clip_alpha_test_blend.sv @@
// Fragment back end: clip test, texel modulation, alpha test and alpha blend.
// Depends on fcatb_pkg, the channel interfaces in fcatb_if and fcatb_chan.
//
// Channels: frag (sink) takes one fragment per transaction: pixel_x, pixel_y,
// source_color, texel_color, dest_color. result (source) returns one
// transaction per fragment, in order: write_enable and result_color (zero
// when the clip or alpha test discards the pixel). cfg (sink) writes one
// register per transaction at addr 0..7; it is always ready. The user must
// write it only while no fragment is in flight; the block does not enforce it.
// Pipeline: six register stages; a fragment accepted into stage 1 moves
// through stages 2 to 6; stage 6 drives result. Throughput: one fragment per
// cycle while result.ready is high, set by the six-stage pipeline's valid bits.
// Stall: each stage holds while the one after it is full and stalled, so
// empty stages keep filling; frag.ready drops only once every stage holds
// a fragment and result.ready is low.
// Reset: pipeline empties, registers return to zero, the clip table to all ones.
module fragment_clip_alpha_test_blend #(
    parameter int COORD_BIAS = fcatb_pkg::COORD_BIAS_DEF,
    parameter int CLIP_RECTS = fcatb_pkg::CLIP_RECTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    fcatb_frag_if.sink  frag,
    fcatb_result_if.source result,
    fcatb_cfg_if.sink   cfg
);

    localparam int STAGES = 6;

    logic [29:0] blend_control_reg;
    logic [11:0] alpha_control_reg;
    logic [15:0] clip_table_reg;
    logic [3:0]  texture_control_reg;
    logic [51:0] clip_rect_reg [CLIP_RECTS];

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] v_next;
    logic [STAGES-1:0] pass_reg;
    logic [STAGES-1:0] pass_next;
    logic [STAGES-1:0] en;

    logic [15:0] c_next [4];
    logic [15:0] c1_reg [4];
    logic [31:0] d1_reg;

    logic [13:0] xb;
    logic [13:0] yb;
    logic [fcatb_pkg::MAX_RECTS-1:0] hit;
    logic        clip_pass;
    logic [7:0]  tex_a;
    logic [15:0] ref255;
    logic        alpha_pass;
    logic [7:0]  q [4];

    fcatb_pkg::stage_en_t  stage_en;
    fcatb_pkg::blend_ctl_t blend_ctl;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_control_reg   <= '0;
            alpha_control_reg   <= '0;
            clip_table_reg      <= fcatb_pkg::CLIP_ALL;
            texture_control_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.addr)
                fcatb_pkg::REG_BLEND:   blend_control_reg   <= cfg.data[29:0];
                fcatb_pkg::REG_ALPHA:   alpha_control_reg   <= cfg.data[11:0];
                fcatb_pkg::REG_CLIP:    clip_table_reg      <= cfg.data[15:0];
                fcatb_pkg::REG_TEXTURE: texture_control_reg <= cfg.data[3:0];
                default: ;
            endcase
        end
    end

    for (genvar r = 0; r < CLIP_RECTS; r++)
    begin : g_rect_reg
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                clip_rect_reg[r] <= '0;
            end
            else if (cfg.valid &&
                     cfg.addr == fcatb_pkg::cfg_addr_t'(int'(fcatb_pkg::REG_RECT0) + r))
            begin
                clip_rect_reg[r] <= cfg.data;
            end
        end
    end

    // stage 1: clip test and modulation
    assign xb = 14'(frag.pixel_x) + 14'(COORD_BIAS);
    assign yb = 14'(frag.pixel_y) + 14'(COORD_BIAS);

    for (genvar r = 0; r < fcatb_pkg::MAX_RECTS; r++)
    begin : g_hit
        if (r < CLIP_RECTS)
        begin : g_used
            assign hit[r] = (xb >= {1'b0, clip_rect_reg[r][12:0]})  &&
                            (xb <  {1'b0, clip_rect_reg[r][38:26]}) &&
                            (yb >= {1'b0, clip_rect_reg[r][25:13]}) &&
                            (yb <  {1'b0, clip_rect_reg[r][51:39]});
        end
        else
        begin : g_unused
            assign hit[r] = 1'b0;
        end
    end

    assign clip_pass = (clip_table_reg == 16'h0000) ||
                       (clip_table_reg == fcatb_pkg::CLIP_ALL) ||
                       clip_table_reg[hit];

    always_comb
    begin
        case (texture_control_reg[3:1])
            fcatb_pkg::SWZ_ZERO: tex_a = 8'h00;
            fcatb_pkg::SWZ_ONE:  tex_a = 8'hff;
            default:             tex_a = frag.texel_color[31:24];
        endcase
        for (int i = 0; i < 4; i++)
        begin
            c_next[i] = {8'h00, frag.source_color[31-8*i -: 8]} *
                        {8'h00, (!texture_control_reg[0]) ? 8'hff :
                                (i == 0) ? tex_a : frag.texel_color[31-8*i -: 8]};
        end
    end

    // stage 2: alpha test
    always_comb
    begin
        ref255 = {alpha_control_reg[7:0], 8'h00} - {8'h00, alpha_control_reg[7:0]};
        case (fcatb_pkg::alpha_func_t'(alpha_control_reg[10:8]))
            fcatb_pkg::AF_NEVER:    alpha_pass = 1'b0;
            fcatb_pkg::AF_LESS:     alpha_pass = c1_reg[0] <  ref255;
            fcatb_pkg::AF_EQUAL:    alpha_pass = c1_reg[0] == ref255;
            fcatb_pkg::AF_LEQUAL:   alpha_pass = c1_reg[0] <= ref255;
            fcatb_pkg::AF_GTHAN:    alpha_pass = c1_reg[0] >  ref255;
            fcatb_pkg::AF_NOTEQUAL: alpha_pass = c1_reg[0] != ref255;
            fcatb_pkg::AF_GEQUAL:   alpha_pass = c1_reg[0] >= ref255;
            default:                alpha_pass = 1'b1;
        endcase
    end

    // stage enables: a stage loads when empty or when the next one loads
    always_comb
    begin
        en[STAGES-1] = !v_reg[STAGES-1] || result.ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
        v_next       = {v_reg[STAGES-2:0], frag.valid};
        pass_next    = {pass_reg[STAGES-2:1],
                        pass_reg[0] && (!alpha_control_reg[11] || alpha_pass),
                        clip_pass};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= '0;
            pass_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (en[k])
                begin
                    v_reg[k]    <= v_next[k];
                    pass_reg[k] <= pass_next[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < 4; i++)
            begin
                c1_reg[i] <= c_next[i];
            end
            d1_reg <= frag.dest_color;
        end
    end

    assign frag.ready = en[0];

    assign stage_en = '{s2: en[1], s3: en[2], s4: en[3], s5: en[4], s6: en[5]};
    assign blend_ctl = '{enable:   blend_control_reg[0],
                         src_code: blend_control_reg[21:16],
                         dst_code: blend_control_reg[29:24]};

    for (genvar i = 0; i < 4; i++)
    begin : g_chan
        fcatb_chan u_chan (
            .clk (clk),
            .en  (stage_en),
            .ctl (blend_ctl),
            .sc  (c1_reg[i]),
            .sa  (c1_reg[0]),
            .d   (d1_reg[31-8*i -: 8]),
            .da  (d1_reg[31:24]),
            .q   (q[i])
        );
    end

    assign result.valid        = v_reg[STAGES-1];
    assign result.write_enable = pass_reg[STAGES-1];
    assign result.result_color = pass_reg[STAGES-1] ? {q[0], q[1], q[2], q[3]} : 32'h0;

endmodule

@@ src/fcatb_checker.sv @@
// Port-level checks of the fragment back end, bound to the top level.
// Depends on fragment_clip_alpha_test_blend_macros.svh.
`include "fragment_clip_alpha_test_blend_macros.svh"

module fcatb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        frag_valid,
    input logic        frag_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic        write_enable,
    input logic [31:0] result_color
);

    logic frag_acc;
    logic go;

    assign frag_acc = frag_valid && frag_ready && rst_n;
    assign go       = res_ready && rst_n;

    `FCATB_ASSERT_NOW(a_discard_zero, res_valid && !write_enable, result_color == 32'h0, "discarded pixel carries color")
    `FCATB_ASSERT_NOW(a_ready_when_drained, !res_valid || res_ready, frag_ready, "input stalled with output free")
    `FCATB_ASSERT_NOW(a_latency, $past(frag_acc, 6) && $past(go, 1) && $past(go, 2) && $past(go, 3) && $past(go, 4) && $past(go, 5), res_valid, "result missing after pipeline latency")
    `FCATB_ASSERT_NEXT(a_stall_hold, res_valid && !res_ready, res_valid && $stable(result_color) && $stable(write_enable), "stalled result changed")

endmodule

bind fragment_clip_alpha_test_blend fcatb_checker u_fcatb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .frag_valid   (frag.valid),
    .frag_ready   (frag.ready),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .write_enable (result.write_enable),
    .result_color (result.result_color)
);
